// ===== sv/dbalu_pkg.sv =====
// ----------------------------------------------------------------------------
// dbalu_pkg
// Shared codes and command/status types for the decimal arithmetic unit.
// ----------------------------------------------------------------------------
package dbalu_pkg;

    // request kinds (unused codes behave like compare)
    localparam logic [2:0] REQ_ADD = 3'd0;
    localparam logic [2:0] REQ_SUB = 3'd1;
    localparam logic [2:0] REQ_MUL = 3'd2;
    localparam logic [2:0] REQ_DIV = 3'd3;
    localparam logic [2:0] REQ_CMP = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NEG  = 3'd1;
    localparam logic [2:0] ST_OVF  = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CHECK,
        DP_ADD,
        DP_SUB,
        DP_NINES,
        DP_DIV0,
        DP_MUL_ADD,
        DP_MUL_SHIFT,
        DP_DIV_SHIFT,
        DP_DIV_SUB,
        DP_DIV_DIGIT,
        DP_SIG_INIT,
        DP_SIG_STEP,
        DP_OUT_WRITE
    } t_dp_op;

    typedef struct packed {
        logic bad;         // some operand digit above nine
        logic a_lt;        // left operand smaller
        logic b_zero;      // right operand is zero
        logic b_top_zero;  // multiplier digit in work is used up
        logic ge;          // remainder >= divisor
        logic sig_done;    // leading zero scan finished
    } t_dp_stat;

endpackage

// ===== sv/dbalu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbalu_ctrl
// Sequencer: accepts an item, steps the datapath through the operation,
// the digit count scan and the output register handshake.
// ----------------------------------------------------------------------------
module dbalu_ctrl
    import dbalu_pkg::*;
#(
    parameter int NUM_DIGITS = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_in_req,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_stat   i_stat,
    output t_dp_op     o_cmd
);

    localparam int CW = $clog2(NUM_DIGITS);
    localparam logic [CW-1:0] LAST = CW'(NUM_DIGITS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DISPATCH,
        S_MUL,
        S_DIV_SHIFT,
        S_DIV_SUB,
        S_SIG_INIT,
        S_SIG,
        S_WRITE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_req, n_req;
    logic          r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_req       = r_req;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = DP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_req   = i_in_req;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd   = DP_CHECK;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_cnt   = '0;
                n_state = S_SIG_INIT;
                if (!i_stat.bad) begin
                    unique case (r_req)
                        REQ_ADD: o_cmd = DP_ADD;
                        REQ_SUB: o_cmd = i_stat.a_lt ? DP_NINES : DP_SUB;
                        REQ_MUL: n_state = S_MUL;
                        REQ_DIV: begin
                            if (i_stat.b_zero) o_cmd = DP_DIV0;
                            else n_state = S_DIV_SHIFT;
                        end
                        default: o_cmd = DP_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                if (!i_stat.b_top_zero) begin
                    o_cmd = DP_MUL_ADD;
                end else if (r_cnt == LAST) begin
                    n_state = S_SIG_INIT;
                end else begin
                    o_cmd = DP_MUL_SHIFT;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV_SHIFT: begin
                o_cmd   = DP_DIV_SHIFT;
                n_state = S_DIV_SUB;
            end
            S_DIV_SUB: begin
                if (i_stat.ge) begin
                    o_cmd = DP_DIV_SUB;
                end else begin
                    o_cmd = DP_DIV_DIGIT;
                    if (r_cnt == LAST) begin
                        n_state = S_SIG_INIT;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_DIV_SHIFT;
                    end
                end
            end
            S_SIG_INIT: begin
                o_cmd   = DP_SIG_INIT;
                n_state = S_SIG;
            end
            S_SIG: begin
                if (!i_stat.sig_done) o_cmd = DP_SIG_STEP;
                else n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = DP_OUT_WRITE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_req       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_req       <= n_req;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/dbalu_dpath.sv =====
// ----------------------------------------------------------------------------
// dbalu_dpath
// Operand, accumulator and remainder registers with one wide BCD adder and
// one wide BCD subtractor; multiply and divide run one add/subtract a cycle.
// ----------------------------------------------------------------------------
module dbalu_dpath
    import dbalu_pkg::*;
#(
    parameter int NUM_DIGITS = 30
) (
    input  logic        i_clk,
    input  t_dp_op      i_cmd,
    input  logic [59:0] i_a_high,
    input  logic [59:0] i_a_low,
    input  logic [59:0] i_b_high,
    input  logic [59:0] i_b_low,
    output t_dp_stat    o_stat,
    output logic [59:0] o_res_high,
    output logic [59:0] o_res_low,
    output logic [4:0]  o_sig_digits,
    output logic        o_a_less,
    output logic        o_a_equal,
    output logic [2:0]  o_status
);

    localparam int W  = 4 * NUM_DIGITS;
    localparam int WX = W + 4;
    localparam int SW = $clog2(NUM_DIGITS + 1);
    localparam logic [W-1:0]  SIXES = {NUM_DIGITS{4'h6}};
    localparam logic [W-1:0]  NINES = {NUM_DIGITS{4'h9}};

    logic [119:0]   a_full, b_full, res_full;
    logic [W-1:0]   r_a, r_b, r_r, r_s;
    logic [WX-1:0]  r_rem;
    logic [3:0]     r_q;
    logic [SW-1:0]  r_sig;
    logic           r_lt, r_eq, r_bad, r_bz;
    logic [2:0]     r_status;

    logic           bad;
    logic [W-1:0]   add_x, add_y, add_sum;
    logic [W:0]     add_t, add_cv;
    logic [WX-1:0]  sub_x, sub_diff;
    logic [WX:0]    sub_d, sub_bv;

    assign a_full = {i_a_high, i_a_low};
    assign b_full = {i_b_high, i_b_low};

    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_a[4*i +: 4] > 4'd9 || r_b[4*i +: 4] > 4'd9) bad = 1'b1;
        end
    end

    // BCD add: binary add with +6 per digit, take back the 6 where no carry
    assign add_x  = (i_cmd == DP_ADD) ? r_a : r_r;
    assign add_y  = (i_cmd == DP_ADD) ? r_b : r_a;
    assign add_t  = {1'b0, add_x} + {1'b0, add_y} + {1'b0, SIXES};
    assign add_cv = {1'b0, add_x} ^ {1'b0, add_y} ^ {1'b0, SIXES} ^ add_t;
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            add_sum[4*i +: 4] = add_cv[4*i+4] ? add_t[4*i +: 4]
                                              : add_t[4*i +: 4] - 4'd6;
        end
    end

    // BCD subtract over one extra digit: fix digits that borrowed by -6
    assign sub_x  = (i_cmd == DP_SUB) ? {4'h0, r_a} : r_rem;
    assign sub_d  = {1'b0, sub_x} - {5'h00, r_b};
    assign sub_bv = {1'b0, sub_x} ^ {5'h00, r_b} ^ sub_d;
    always_comb begin
        for (int i = 0; i <= NUM_DIGITS; i++) begin
            sub_diff[4*i +: 4] = sub_bv[4*i+4] ? sub_d[4*i +: 4] - 4'd6
                                               : sub_d[4*i +: 4];
        end
    end

    assign o_stat.bad        = r_bad;
    assign o_stat.a_lt       = r_lt;
    assign o_stat.b_zero     = r_bz;
    assign o_stat.b_top_zero = (r_b[W-1 -: 4] == 4'h0);
    // compared on the registers so the status does not depend on the command
    assign o_stat.ge         = (r_rem >= {4'h0, r_b});
    assign o_stat.sig_done   = (r_sig == '0) || (r_s[W-1 -: 4] != 4'h0);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            DP_IDLE: ;
            DP_LOAD: begin
                r_a <= a_full[W-1:0];
                r_b <= b_full[W-1:0];
            end
            DP_CHECK: begin
                r_bad    <= bad;
                r_lt     <= ~bad & (r_a < r_b);
                r_eq     <= ~bad & (r_a == r_b);
                r_bz     <= (r_b == '0);
                r_status <= bad ? ST_BAD : ST_OK;
                r_r      <= '0;
                r_rem    <= '0;
            end
            DP_ADD: begin
                r_r <= add_sum;
                if (add_t[W]) r_status <= ST_OVF;
            end
            DP_SUB:   r_r <= sub_diff[W-1:0];
            DP_NINES: begin
                r_r      <= NINES;
                r_status <= ST_NEG;
            end
            DP_DIV0:  r_status <= ST_DIV0;
            DP_MUL_ADD: begin
                r_r            <= add_sum;
                r_b[W-1 -: 4]  <= r_b[W-1 -: 4] - 4'd1;
                if (add_t[W]) r_status <= ST_OVF;
            end
            DP_MUL_SHIFT: begin
                r_r <= {r_r[W-5:0], 4'h0};
                r_b <= {r_b[W-5:0], 4'h0};
                if (r_r[W-1 -: 4] != 4'h0) r_status <= ST_OVF;
            end
            DP_DIV_SHIFT: begin
                r_rem <= {r_rem[W-1:0], r_a[W-1 -: 4]};
                r_a   <= {r_a[W-5:0], 4'h0};
                r_q   <= 4'h0;
            end
            DP_DIV_SUB: begin
                r_rem <= sub_diff;
                r_q   <= r_q + 4'd1;
            end
            DP_DIV_DIGIT: r_r <= {r_r[W-5:0], r_q};
            DP_SIG_INIT: begin
                r_s   <= r_r;
                r_sig <= SW'(NUM_DIGITS);
            end
            DP_SIG_STEP: begin
                r_s   <= {r_s[W-5:0], 4'h0};
                r_sig <= r_sig - 1'b1;
            end
            DP_OUT_WRITE: begin
                o_res_high   <= res_full[119:60];
                o_res_low    <= res_full[59:0];
                o_sig_digits <= 5'(r_sig);
                o_a_less     <= r_lt;
                o_a_equal    <= r_eq;
                o_status     <= r_status;
            end
            default: ;
        endcase
    end

    assign res_full = 120'(r_r);

endmodule

// ===== sv/decimal_bigint_alu_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_bigint_alu_unit
// Unsigned packed-BCD arithmetic unit: add, subtract, multiply, floor divide
// and compare on NUM_DIGITS-digit operands.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_axis    in   a_high, a_low, b_high, b_low (240b)     req_type
//  m_axis    out  res_high, res_low, sig_digits,          status
//                 a_less, a_equal (128b)
//
//  One item at a time. Multiply: one BCD add per unit of each multiplier
//  digit plus one shift between digits; divide: one subtract per quotient unit
//  plus a shift per digit. A final leading-zero scan follows every operation.
//  Reset is synchronous and clears the sequencer and the output valid.
//  A held result does not block acceptance of the next item.
// ----------------------------------------------------------------------------
module decimal_bigint_alu_unit
    import dbalu_pkg::*;
#(
    parameter int NUM_DIGITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [239:0] i_s_axis_tdata,  // a_high, a_low, b_high, b_low
    input  logic [2:0]   i_s_axis_tuser,  // req_type
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,  // res_high, res_low, sig_digits,
                                          // a_less, a_equal, zero pad
    output logic [2:0]   o_m_axis_tuser   // status
);

    t_dp_op      cmd;
    t_dp_stat    stat;
    logic [59:0] res_high, res_low;
    logic [4:0]  sig_digits;
    logic        a_less, a_equal;

    dbalu_ctrl #(.NUM_DIGITS(NUM_DIGITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_req    (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    dbalu_dpath #(.NUM_DIGITS(NUM_DIGITS)) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_a_high     (i_s_axis_tdata[59:0]),
        .i_a_low      (i_s_axis_tdata[119:60]),
        .i_b_high     (i_s_axis_tdata[179:120]),
        .i_b_low      (i_s_axis_tdata[239:180]),
        .o_stat       (stat),
        .o_res_high   (res_high),
        .o_res_low    (res_low),
        .o_sig_digits (sig_digits),
        .o_a_less     (a_less),
        .o_a_equal    (a_equal),
        .o_status     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, a_equal, a_less, sig_digits, res_low, res_high};

endmodule

// ===== dv/decimal_bigint_alu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_bigint_alu_checker
// Watches both item channels of the decimal arithmetic unit. It predicts each
// result with binary big-integer arithmetic and checks the results in order.
// ----------------------------------------------------------------------------
module decimal_bigint_alu_checker
    import dbalu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [239:0] i_s_tdata,   // a_high, a_low, b_high, b_low
    input  logic [2:0]   i_s_tuser,   // req_type
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [127:0] i_m_tdata,   // res_high, res_low, sig_digits, a_less, a_equal
    input  logic [2:0]   i_m_tuser,   // status
    output int           o_fail_cnt,
    output int           o_pending,
    output int           o_result_cnt
);

    localparam logic [127:0] TEN30 = 128'd1000000000000000000000000000000;

    typedef struct packed {
        logic [59:0] res_high;
        logic [59:0] res_low;
        logic [4:0]  sig_digits;
        logic        a_less;
        logic        a_equal;
        logic [2:0]  status;
    } t_alu_result;

    t_alu_result expected_results[$];

    function automatic logic has_bad_digit(input logic [119:0] v);
        logic bad;
        bad = 1'b0;
        for (int i = 0; i < 30; i++) begin
            if (v[4*i +: 4] > 4'd9) bad = 1'b1;
        end
        return bad;
    endfunction

    function automatic logic [127:0] bcd_to_bin(input logic [119:0] v);
        logic [127:0] acc;
        acc = '0;
        for (int i = 29; i >= 0; i--) begin
            acc = acc * 10 + v[4*i +: 4];
        end
        return acc;
    endfunction

    function automatic logic [119:0] bin_to_bcd(input logic [127:0] v);
        logic [119:0] d;
        logic [127:0] rest;
        d = '0;
        rest = v;
        for (int i = 0; i < 30; i++) begin
            d[4*i +: 4] = 4'(rest % 10);
            rest = rest / 10;
        end
        return d;
    endfunction

    function automatic t_alu_result predict_result(input logic [2:0] op,
                                                   input logic [239:0] d);
        logic [119:0] a_bcd, b_bcd, r_bcd;
        logic [127:0] a, b, r;
        logic [255:0] prod;
        t_alu_result e;
        a_bcd = {d[59:0], d[119:60]};
        b_bcd = {d[179:120], d[239:180]};
        e = '0;
        if (has_bad_digit(a_bcd) || has_bad_digit(b_bcd)) begin
            e.status = ST_BAD;
            return e;
        end
        a = bcd_to_bin(a_bcd);
        b = bcd_to_bin(b_bcd);
        e.a_less = a < b;
        e.a_equal = a == b;
        e.status = ST_OK;
        r = '0;
        case (op)
            REQ_ADD: begin
                r = a + b;
                if (r >= TEN30) begin
                    r = r - TEN30;
                    e.status = ST_OVF;
                end
            end
            REQ_SUB: begin
                if (a < b) begin
                    r = TEN30 - 1;
                    e.status = ST_NEG;
                end else begin
                    r = a - b;
                end
            end
            REQ_MUL: begin
                prod = {128'b0, a} * {128'b0, b};
                if (prod >= {128'b0, TEN30}) e.status = ST_OVF;
                r = 128'(prod % {128'b0, TEN30});
            end
            REQ_DIV: begin
                if (b == 0) e.status = ST_DIV0;
                else r = a / b;
            end
            default: ;
        endcase
        r_bcd = bin_to_bcd(r);
        e.res_high = r_bcd[119:60];
        e.res_low = r_bcd[59:0];
        for (int i = 0; i < 30; i++) begin
            if (r_bcd[4*i +: 4] != 0) e.sig_digits = 5'(i + 1);
        end
        return e;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, got_v);
            o_fail_cnt++;
        end
    endtask

    initial begin
        o_fail_cnt = 0;
        o_result_cnt = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_alu_result got, exp_r;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_result(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                o_result_cnt++;
                got.res_high = i_m_tdata[59:0];
                got.res_low = i_m_tdata[119:60];
                got.sig_digits = i_m_tdata[124:120];
                got.a_less = i_m_tdata[125];
                got.a_equal = i_m_tdata[126];
                got.status = i_m_tuser;
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected item: actual %h status %0d", $time,
                             i_m_tdata, i_m_tuser);
                    o_fail_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("res_high", exp_r.res_high, got.res_high);
                    check_field("res_low", exp_r.res_low, got.res_low);
                    check_field("sig_digits", exp_r.sig_digits, got.sig_digits);
                    check_field("a_less", exp_r.a_less, got.a_less);
                    check_field("a_equal", exp_r.a_equal, got.a_equal);
                    check_field("status", exp_r.status, got.status);
                end
            end
        end
    end

endmodule

// ===== dv/decimal_bigint_alu_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_bigint_alu_unit_tb
// Drives directed and random BCD requests of every operation into the unit
// under several idle and stall patterns; the checker judges the results.
// ----------------------------------------------------------------------------
module decimal_bigint_alu_unit_tb
    import dbalu_pkg::*;
;

    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [119:0] ALL_NINES = {30{4'h9}};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic [2:0]   s_tuser = REQ_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;

    int idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int hold_cnt = 0;
    logic hold_done = 1'b0;
    int cycle_cnt = 0;
    int item_cnt = 0;
    int fail_cnt, pending, result_cnt;

    always #5 i_clk = ~i_clk;

    decimal_bigint_alu_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    decimal_bigint_alu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_result_cnt (result_cnt)
    );

    // receiver; one long hold-off when the stall phase begins fills the unit
    always @(posedge i_clk) begin
        if (idle_mode == 2 && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= 3000;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_tready <= $urandom_range(99) >= 56;
        end else if (idle_mode == 3) begin
            m_tready <= $urandom_range(99) >= 20;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [239:0] pack_operands(input logic [119:0] a,
                                                   input logic [119:0] b);
        return {b[59:0], b[119:60], a[59:0], a[119:60]};
    endfunction

    // random decimal with a random count of significant digits, now and then with a digit above nine
    function automatic logic [119:0] rand_decimal();
        logic [119:0] v;
        int n;
        v = '0;
        n = ($urandom_range(7) == 0) ? 0 : $urandom_range(30, 1);
        if ($urandom_range(3) == 0) n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
            v[4*i +: 4] = 4'($urandom_range(9));
        end
        if ($urandom_range(15) == 0) v[4*$urandom_range(29) +: 4] = 4'($urandom_range(15, 10));
        return v;
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [239:0] d);
        int pct;
        pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 20 : 0;
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        item_cnt++;
    endtask

    initial begin
        logic [119:0] a, b;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_item(REQ_ADD, pack_operands(ALL_NINES, 120'd1));
        send_item(REQ_ADD, pack_operands('0, '0));
        send_item(REQ_SUB, pack_operands(120'h5, 120'h12));
        send_item(REQ_SUB, pack_operands(ALL_NINES, ALL_NINES));
        send_item(REQ_SUB, pack_operands(120'h1000, 120'h1));
        send_item(REQ_MUL, pack_operands(ALL_NINES, ALL_NINES));
        send_item(REQ_MUL, pack_operands(120'h123, 120'h45));
        send_item(REQ_MUL, pack_operands(ALL_NINES, '0));
        send_item(REQ_DIV, pack_operands(120'h777, '0));
        send_item(REQ_DIV, pack_operands('0, 120'h3));
        send_item(REQ_DIV, pack_operands(ALL_NINES, 120'h1));
        send_item(REQ_DIV, pack_operands(ALL_NINES, 120'h7));
        send_item(REQ_DIV, pack_operands(120'h3, ALL_NINES));
        send_item(REQ_CMP, pack_operands(120'h42, 120'h42));
        send_item(REQ_CMP, pack_operands(120'h41, 120'h42));
        send_item(REQ_CMP, pack_operands(ALL_NINES, 120'h1));
        send_item(3'd5, pack_operands(120'h8, 120'h9));
        send_item(3'd6, pack_operands(120'h9, 120'h8));
        send_item(3'd7, pack_operands(120'h9, 120'h9));
        send_item(REQ_ADD, pack_operands({4'hF, 116'h0}, 120'h1));
        send_item(REQ_SUB, pack_operands(120'hA, 120'h1));
        send_item(REQ_MUL, pack_operands(120'h1, {60'hB, 60'h0}));
        send_item(REQ_DIV, pack_operands(120'h1, {56'h0, 4'hC, 60'h0}));
        send_item(REQ_CMP, pack_operands({120{1'b1}}, {120{1'b1}}));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_mode = i / (RANDOM_ITEMS / 4);
            a = rand_decimal();
            b = rand_decimal();
            send_item(3'($urandom_range(7) < 7 ? $urandom_range(4) : $urandom_range(7, 5)),
                      pack_operands(a, b));
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked: all five operations, unused codes,",
                 item_cnt, result_cnt);
        $display("bad digits and edge operands under free-running, idle and stall patterns");
        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
